### rtl/mt_pkg.sv
package mt_pkg;

	localparam int WORD_W           = 32;
	localparam int STATE_WORDS_DEF  = 624;
	localparam int TWIST_OFFSET_DEF = 397;

	localparam logic [WORD_W-1:0] KNUTH_MULT   = 32'd1812433253;
	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
	localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h80000000;
	localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fffffff;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic fill_we;   // write the seeding recurrence word into the table
		logic load_seed; // start a new seeding recurrence from the seed field
		logic rd_en;     // read the next and far words for a draw
		logic adv;       // write back the twisted word and load the output register
	} ctl_t;

	function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
		input logic [WORD_W-1:0] nxt, input logic [WORD_W-1:0] far);
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] r;
		y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
		r = far ^ (y >> 1);
		if (y[0]) begin
			r = r ^ TWIST_MATRIX;
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

### rtl/mt_in_if.sv
interface mt_in_if;
	import mt_pkg::*;

	logic              valid;
	logic              ready;
	logic              mode;
	logic [WORD_W-1:0] seed;

	modport source (output valid, output mode, output seed, input ready);
	modport sink (input valid, input mode, input seed, output ready);
endinterface

### rtl/mt_out_if.sv
interface mt_out_if;
	import mt_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink (input valid, input random_word, output ready);
endinterface

### rtl/mt_ctrl.sv
module mt_ctrl #(
	parameter int STATE_WORDS  = mt_pkg::STATE_WORDS_DEF,
	parameter int TWIST_OFFSET = mt_pkg::TWIST_OFFSET_DEF,
	localparam int AW = $clog2(STATE_WORDS),
	localparam int IW = $clog2(STATE_WORDS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_mode,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output mt_pkg::ctl_t  ctl,
	output logic [AW-1:0] fill_addr,
	output logic [AW-1:0] rd_k,
	output logic [AW-1:0] rd_addr_n,
	output logic [AW-1:0] rd_addr_f
);
	import mt_pkg::*;

	localparam logic ST_FILL = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	localparam logic [AW-1:0] LAST_K = AW'(STATE_WORDS - 1);
	localparam logic [AW-1:0] FAR_UP = AW'(TWIST_OFFSET);
	localparam logic [AW-1:0] FAR_DN = AW'(STATE_WORDS - TWIST_OFFSET);
	localparam logic [IW-1:0] IDX_END = IW'(STATE_WORDS);

	logic          state_q;
	logic [AW-1:0] cnt_q;
	logic [IW-1:0] idx_q;
	logic          s1_valid_q;
	logic          out_valid_q;

	logic          adv;
	logic          draw_acc;
	logic          seed_acc;
	logic [AW-1:0] k;

	assign adv      = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_RUN) && (!s1_valid_q || adv);
	assign draw_acc = in_valid && in_ready && !in_mode;
	assign seed_acc = in_valid && in_ready && in_mode;

	// A draw at the end of the table starts a new round at word zero; the
	// twist of each word is done on the draw that reads it.
	assign k         = (idx_q == IDX_END) ? '0 : idx_q[AW-1:0];
	assign rd_k      = k;
	assign rd_addr_n = (k == LAST_K) ? '0 : k + AW'(1);
	assign rd_addr_f = (k < FAR_DN) ? k + FAR_UP : k - FAR_DN;
	assign fill_addr = cnt_q;

	always_comb begin
		ctl           = '0;
		ctl.fill_we   = (state_q == ST_FILL);
		ctl.load_seed = seed_acc;
		ctl.rd_en     = draw_acc;
		ctl.adv       = adv;
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			cnt_q       <= '0;
			idx_q       <= IDX_END;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_FILL: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == LAST_K) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (seed_acc) begin
						state_q <= ST_FILL;
						cnt_q   <= '0;
					end
				end
				default: begin
					state_q <= ST_FILL;
					cnt_q   <= '0;
				end
			endcase

			if (seed_acc) begin
				idx_q <= IDX_END;
			end else if (draw_acc) begin
				idx_q <= IW'(k) + IW'(1);
			end

			if (draw_acc) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end

			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/mt_datapath.sv
module mt_datapath #(
	parameter int STATE_WORDS = mt_pkg::STATE_WORDS_DEF,
	localparam int AW = $clog2(STATE_WORDS)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mt_pkg::ctl_t              ctl,
	input  logic [mt_pkg::WORD_W-1:0] seed,
	input  logic [AW-1:0]             fill_addr,
	input  logic [AW-1:0]             rd_k,
	input  logic [AW-1:0]             rd_addr_n,
	input  logic [AW-1:0]             rd_addr_f,
	output logic [mt_pkg::WORD_W-1:0] random_word
);
	import mt_pkg::*;

	logic [WORD_W-1:0] mem [STATE_WORDS];

	logic [WORD_W-1:0] prev_q;
	logic [WORD_W-1:0] cur_q;
	logic [WORD_W-1:0] nxt_s1;
	logic [WORD_W-1:0] far_s1;
	logic [AW-1:0]     k_s1;
	logic [WORD_W-1:0] word_q;

	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] prod;
	logic [WORD_W-1:0] twisted;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;

	// Seeding recurrence: one multiply per cycle, registered in prev_q.
	assign mix  = prev_q ^ (prev_q >> 30);
	assign prod = KNUTH_MULT * mix;

	// cur_q always holds the not yet twisted word at the draw position.
	assign twisted = twist_word(cur_q, nxt_s1, far_s1);

	assign wr_en   = ctl.fill_we || ctl.adv;
	assign wr_addr = ctl.fill_we ? fill_addr : k_s1;
	assign wr_data = ctl.fill_we ? prev_q : twisted;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			nxt_s1 <= mem[rd_addr_n];
			far_s1 <= mem[rd_addr_f];
			k_s1   <= rd_k;
		end
		if (ctl.adv) begin
			word_q <= temper(twisted);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			cur_q  <= '0;
		end else begin
			if (ctl.load_seed) begin
				prev_q <= seed;
			end else if (ctl.fill_we) begin
				prev_q <= prod + WORD_W'(fill_addr) + WORD_W'(1);
			end

			if (ctl.load_seed) begin
				cur_q <= seed;
			end else if (ctl.adv) begin
				cur_q <= nxt_s1;
			end
		end
	end

	assign random_word = word_q;

endmodule

### rtl/mersenne_twister_prng.sv
// Draw: the table words are registered, then the output register is loaded;
// draws sustain one per cycle while results are taken, each twisting only the
// table word it reads. Seed: no result; the table is refilled one word per cycle
// through the seeding multiplier, and no item is taken during the fill.
// Reset: asynchronous; after it the same fill runs with seed 0.
module mersenne_twister_prng #(
	parameter int STATE_WORDS  = mt_pkg::STATE_WORDS_DEF,
	parameter int TWIST_OFFSET = mt_pkg::TWIST_OFFSET_DEF
) (
	input logic     clk,
	input logic     arst_n,
	mt_in_if.sink   item,
	mt_out_if.source result
);
	import mt_pkg::*;

	localparam int AW = $clog2(STATE_WORDS);

	ctl_t          ctl;
	logic [AW-1:0] fill_addr;
	logic [AW-1:0] rd_k;
	logic [AW-1:0] rd_addr_n;
	logic [AW-1:0] rd_addr_f;

	mt_ctrl #(
		.STATE_WORDS (STATE_WORDS),
		.TWIST_OFFSET(TWIST_OFFSET)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_mode  (item.mode),
		.in_ready (item.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.ctl      (ctl),
		.fill_addr(fill_addr),
		.rd_k     (rd_k),
		.rd_addr_n(rd_addr_n),
		.rd_addr_f(rd_addr_f)
	);

	mt_datapath #(
		.STATE_WORDS(STATE_WORDS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.seed       (item.seed),
		.fill_addr  (fill_addr),
		.rd_k       (rd_k),
		.rd_addr_n  (rd_addr_n),
		.rd_addr_f  (rd_addr_f),
		.random_word(result.random_word)
	);

	// No item is taken while the table is being refilled.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fill_we |-> !(item.valid && item.ready))
		else $error("item transfer during table fill");

	// The single write port is never claimed by the fill and a draw at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.fill_we && ctl.adv))
		else $error("table write port conflict");

	// A seed transfer starts the fill in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.mode) |=> ctl.fill_we)
		else $error("seed transfer did not start a fill");

	// A draw transfer always reads the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && !item.mode) |-> ctl.rd_en)
		else $error("draw transfer without table read");

endmodule

### dv/mersenne_twister_prng_tb.sv
`timescale 1ns / 1ps

module mersenne_twister_prng_tb;
	import mt_pkg::*;

	localparam int TABLE_WORDS = STATE_WORDS_DEF;
	localparam int FAR_OFFSET  = TWIST_OFFSET_DEF;
	localparam int RAND_ITEMS  = 720;
	localparam int PHASE_LEN   = 240;
	localparam int HOLD_LEN    = 300;
	localparam int DRAIN_WAIT  = 650;
	localparam int CYCLE_LIMIT = 300000;

	typedef enum logic {
		MODE_DRAW = 1'b0,
		MODE_SEED = 1'b1
	} mode_e;

	// Predicts the generator word by word and holds the words still to come out.
	class word_scoreboard;
		logic [WORD_W-1:0] mt_words [TABLE_WORDS];
		int unsigned       next_idx;
		logic [WORD_W-1:0] pending_words [$];
		int unsigned       mismatches;
		int unsigned       draws;
		int unsigned       seeds;
		int unsigned       regens;
		int unsigned       checked;

		function new();
			mismatches = 0;
			draws      = 0;
			seeds      = 0;
			regens     = 0;
			checked    = 0;
			reseed_table(32'd0);
		endfunction

		function void reseed_table(input logic [WORD_W-1:0] s);
			logic [WORD_W-1:0] mix;
			mt_words[0] = s;
			for (int i = 1; i < TABLE_WORDS; i++) begin
				mix = mt_words[i-1] ^ {30'd0, mt_words[i-1][31:30]};
				mt_words[i] = mix * 32'd1812433253 + WORD_W'(i);
			end
			next_idx = TABLE_WORDS;
		endfunction

		function void twist_table();
			logic [WORD_W-1:0] y;
			logic [WORD_W-1:0] r;
			for (int k = 0; k < TABLE_WORDS; k++) begin
				y = {mt_words[k][31], mt_words[(k + 1) % TABLE_WORDS][30:0]};
				r = mt_words[(k + FAR_OFFSET) % TABLE_WORDS] ^ {1'b0, y[31:1]};
				if (y[0]) begin
					r = r ^ 32'h9908b0df;
				end
				mt_words[k] = r;
			end
			next_idx = 0;
			regens++;
		endfunction

		function logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] w);
			logic [WORD_W-1:0] y;
			y = w ^ {11'd0, w[31:11]};
			y = y ^ ({y[24:0], 7'd0} & 32'h9d2c5680);
			y = y ^ ({y[16:0], 15'd0} & 32'hefc60000);
			y = y ^ {18'd0, y[31:18]};
			return y;
		endfunction

		function void note_item(input mode_e m, input logic [WORD_W-1:0] s);
			if (m == MODE_SEED) begin
				reseed_table(s);
				seeds++;
			end else begin
				if (next_idx >= TABLE_WORDS) begin
					twist_table();
				end
				pending_words.push_back(temper_word(mt_words[next_idx]));
				next_idx++;
				draws++;
			end
		endfunction

		task report_mismatch(input string what);
			mismatches++;
			$display("[%0t] MISMATCH: %s", $time, what);
		endtask

		task check_word(input logic [WORD_W-1:0] got);
			logic [WORD_W-1:0] want;
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("random_word %08h with no draw outstanding", got));
			end else begin
				want = pending_words.pop_front();
				checked++;
				if (got !== want) begin
					report_mismatch($sformatf("random_word %08h, expected %08h (word %0d)",
						got, want, checked));
				end
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	mt_in_if  item_ch ();
	mt_out_if result_ch ();

	mersenne_twister_prng i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	word_scoreboard board = new();

	int unsigned src_idle_pct = 18;
	int unsigned snk_idle_pct = 51;
	int unsigned hold_req     = 0;
	int unsigned hold_left    = 0;
	int unsigned held_cycles  = 0;
	int unsigned cycles       = 0;

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d words outstanding", cycles,
					board.pending_words.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Result side: checks each transfer, then picks ready for the next cycle.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				board.check_word(result_ch.random_word);
			end
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				held_cycles++;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// Called at a clock edge; returns at the edge where the transfer happens.
	task automatic send_item(input mode_e m, input logic [WORD_W-1:0] s);
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			item_ch.mode  <= 1'($urandom_range(1));
			item_ch.seed  <= $urandom();
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mode  <= m;
		item_ch.seed  <= s;
		@(posedge clk);
		while (!item_ch.ready) begin
			@(posedge clk);
		end
		board.note_item(m, s);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending_words.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		mode_e             m;
		logic [WORD_W-1:0] s;

		arst_n        = 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.mode  <= MODE_DRAW;
		item_ch.seed  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Draws straight after reset come from the table seeded with zero.
		send_item(MODE_DRAW, 32'h0000_0000);
		send_item(MODE_DRAW, 32'hffff_ffff);
		send_item(MODE_DRAW, 32'h1234_5678);
		send_item(MODE_SEED, 32'h0000_0000);
		send_item(MODE_DRAW, 32'h0000_0000);
		send_item(MODE_DRAW, 32'h0000_0000);
		send_item(MODE_SEED, 32'hffff_ffff);
		send_item(MODE_DRAW, 32'hffff_ffff);
		send_item(MODE_DRAW, 32'hffff_ffff);
		send_item(MODE_SEED, 32'd5489);
		send_item(MODE_DRAW, 32'h0000_0000);
		// Back-to-back seeds: only the second one may take effect.
		send_item(MODE_SEED, 32'h0000_0001);
		send_item(MODE_SEED, 32'h0000_0002);
		send_item(MODE_DRAW, 32'h8000_0000);
		send_item(MODE_SEED, 32'h8000_0000);
		send_item(MODE_DRAW, 32'h7fff_ffff);
		send_item(MODE_SEED, 32'h5555_5555);
		send_item(MODE_DRAW, 32'haaaa_aaaa);
		send_item(MODE_DRAW, 32'h5555_5555);
		send_item(MODE_SEED, 32'haaaa_aaaa);
		send_item(MODE_DRAW, 32'h0000_0000);
		wait_drained();

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == PHASE_LEN) begin
				wait_drained();
				src_idle_pct = 51;
				snk_idle_pct = 18;
			end
			if (n == 2 * PHASE_LEN) begin
				wait_drained();
				src_idle_pct = 0;
				snk_idle_pct = 0;
				// Sender keeps offering draws while the result side is held off.
				hold_req = HOLD_LEN;
			end
			// A long run of draws carries the read index past the table end.
			if (n >= 60 && n < 710) begin
				m = MODE_DRAW;
			end else begin
				m = ($urandom_range(7) == 0) ? MODE_SEED : MODE_DRAW;
			end
			s = $urandom();
			send_item(m, s);
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (board.pending_words.size() != 0) begin
			board.report_mismatch($sformatf("%0d expected words never came out",
				board.pending_words.size()));
		end

		$display("covered %0d draws and %0d seeds, %0d full table twists, %0d words checked",
			board.draws, board.seeds, board.regens, board.checked);
		$display("result side held off for %0d cycles in one stretch, %0d mismatches",
			held_cycles, board.mismatches);
		if (board.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
